// ===== rtl/core/pal_pkg.sv =====
// Shared types and codes for the positional array list.
// Command and result words, queue entry, opcode and status codes.
// No dependencies.
package pal_pkg;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]          op;
    logic [7:0]          position;
    logic signed [31:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [7:0]          found_position;
    logic signed [31:0]  read_value;
    logic [7:0]          element_count;
  } result_t;

  // What the back end has to do with a classified command.
  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_INSERT = 3'd1,
    K_DELETE = 3'd2,
    K_SEARCH = 3'd3,
    K_READ   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [2:0]          status;
    logic [7:0]          count;
    logic signed [31:0]  value;
  } q_item_t;

endpackage

// ===== rtl/core/pal_front.sv =====
// Front end: checks each command against the element count and classifies it.
// Owns the element count. Depends on pal_pkg.
module pal_front import pal_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  cmd_t          cmd,
  output q_item_t       item,
  output logic [AW-1:0] pidx,
  output logic [AW-1:0] lim
);

  localparam int MW = ((CW > 8) ? CW : 8) + 1;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [MW-1:0] c_w;
  logic [MW-1:0] p_w;
  logic [MW-1:0] c_m1;
  logic [MW-1:0] p_m1;

  assign c_w  = MW'(count);
  assign p_w  = MW'(cmd.position);
  assign c_m1 = c_w - MW'(1);
  assign p_m1 = p_w - MW'(1);

  always_comb begin
    item.kind   = K_NONE;
    item.status = ST_OK;
    item.value  = cmd.value;
    count_next  = count;
    pidx        = AW'(p_m1);
    lim         = AW'(c_m1);
    case (cmd.op)
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_INSERT: begin
        lim = AW'(c_w);
        if (c_w >= MW'(DEPTH)) begin
          item.status = ST_FULL;
        end else if (p_w == '0 || p_w > c_w + MW'(1)) begin
          item.status = ST_BADPOS;
        end else begin
          item.kind  = K_INSERT;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (c_w == '0) begin
          item.status = ST_EMPTY;
        end else if (p_w == '0 || p_w > c_w) begin
          item.status = ST_BADPOS;
        end else begin
          item.kind  = K_DELETE;
          count_next = count - CW'(1);
        end
      end
      OP_SEARCH: begin
        pidx = '0;
        if (c_w == '0) begin
          item.status = ST_EMPTY;
        end else begin
          item.kind = K_SEARCH;
        end
      end
      OP_READ: begin
        if (c_w == '0) begin
          item.status = ST_EMPTY;
        end else if (p_w == '0 || p_w > c_w) begin
          item.status = ST_BADPOS;
        end else begin
          item.kind = K_READ;
        end
      end
      default: begin
        item.status = ST_BADPOS;
      end
    endcase
    item.count = 8'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/pal_queue.sv =====
// Short FIFO between the front end and the back end.
// Generic word width. Depends on pal_pkg for the depth.
module pal_queue import pal_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid,
  output logic         full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;

  assign valid = (fill != '0);
  assign full  = (fill == NW'(QUEUE_DEPTH));
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/pal_back.sv =====
// Back end: entry memory and the sequencer that shifts, searches and reads it.
// Takes classified commands from the queue and drives the result. Depends on pal_pkg.
module pal_back import pal_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  q_item_t       q_item,
  input  logic [AW-1:0] q_pidx,
  input  logic [AW-1:0] q_lim,
  output logic          pop,
  output logic          done,
  output result_t       result
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SHIFT_UP = 5'b00010,
    S_SHIFT_DN = 5'b00100,
    S_SEARCH   = 5'b01000,
    S_READ     = 5'b10000
  } state_t;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  state_t        state;
  q_item_t       item;
  logic [AW-1:0] pidx;
  logic [AW-1:0] lim;
  logic [AW-1:0] rp;
  logic [AW-1:0] paddr;
  logic          iss;
  logic          pend;
  logic          hit;
  logic [AW:0]   hit_pos;

  assign hit     = pend && (rdata == item.value);
  assign hit_pos = {1'b0, paddr} + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    pop   = 1'b0;
    we    = 1'b0;
    waddr = paddr;
    wdata = rdata;
    re    = 1'b0;
    raddr = rp;
    case (state)
      S_IDLE: begin
        pop = q_valid;
        if (q_valid && q_item.kind == K_INSERT && q_pidx == q_lim) begin
          we    = 1'b1;
          waddr = q_pidx;
          wdata = q_item.value;
        end
        if (q_valid && q_item.kind == K_READ) begin
          re    = 1'b1;
          raddr = q_pidx;
        end
      end
      S_SHIFT_UP: begin
        re = iss;
        if (pend) begin
          we    = 1'b1;
          waddr = paddr + AW'(1);
        end else if (!iss) begin
          we    = 1'b1;
          waddr = pidx;
          wdata = item.value;
        end
      end
      S_SHIFT_DN: begin
        re = iss;
        if (pend) begin
          we    = 1'b1;
          waddr = paddr - AW'(1);
        end
      end
      S_SEARCH: begin
        re = iss;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iss   <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            pidx <= q_pidx;
            lim  <= q_lim;
            result.status         <= q_item.status;
            result.found_position <= '0;
            result.read_value     <= '0;
            result.element_count  <= q_item.count;
            case (q_item.kind)
              K_INSERT: begin
                if (q_pidx == q_lim) begin
                  done <= 1'b1;
                end else begin
                  rp    <= q_lim - AW'(1);
                  iss   <= 1'b1;
                  state <= S_SHIFT_UP;
                end
              end
              K_DELETE: begin
                if (q_pidx == q_lim) begin
                  done <= 1'b1;
                end else begin
                  rp    <= q_pidx + AW'(1);
                  iss   <= 1'b1;
                  state <= S_SHIFT_DN;
                end
              end
              K_SEARCH: begin
                rp    <= '0;
                iss   <= 1'b1;
                state <= S_SEARCH;
              end
              K_READ: begin
                state <= S_READ;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          pend  <= iss;
          paddr <= rp;
          if (iss) begin
            if (rp == pidx) begin
              iss <= 1'b0;
            end else begin
              rp <= rp - AW'(1);
            end
          end
          if (!iss && !pend) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHIFT_DN: begin
          pend  <= iss;
          paddr <= rp;
          if (iss) begin
            if (rp == lim) begin
              iss <= 1'b0;
            end else begin
              rp <= rp + AW'(1);
            end
          end
          if (!iss && !pend) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SEARCH: begin
          pend  <= iss;
          paddr <= rp;
          if (iss) begin
            if (rp == lim) begin
              iss <= 1'b0;
            end else begin
              rp <= rp + AW'(1);
            end
          end
          // The first matching word ends the walk; reads already issued are dropped.
          if (hit) begin
            result.status         <= ST_OK;
            result.found_position <= 8'(hit_pos);
            done  <= 1'b1;
            iss   <= 1'b0;
            pend  <= 1'b0;
            state <= S_IDLE;
          end else if (pend && paddr == lim) begin
            result.status <= ST_NOTFOUND;
            done  <= 1'b1;
            iss   <= 1'b0;
            pend  <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          result.read_value <= rdata;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/positional_array_list.sv =====
// Top level of the positional array list: front end, queue and back end.
// Depends on pal_pkg, pal_front, pal_queue and pal_back.
//
// A command word is taken when start is high and busy is low; each command gives
// exactly one result word, shown on result for one cycle while done is high, and
// the receiver must take it then. The front end checks every command against the
// element count at once, so refused commands, clear, and an append at the end of
// the list finish when the back end takes them, and a read after its memory read.
// The entries sit in a memory with one read and one write port, and shifting and
// searching move one entry per cycle through it: an insert moves the entries from
// its position on up, a delete moves those after it down, and a search walks from
// the first entry to the first match. Up to two commands wait in a queue while
// the back end works; busy is high while that queue is full. The memory needs no
// clearing after reset, since only positions below the count are read.
module positional_array_list import pal_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = $bits(q_item_t) + 2 * AW;

  logic          accept;
  q_item_t       f_item;
  logic [AW-1:0] f_pidx;
  logic [AW-1:0] f_lim;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic          q_valid;
  logic          q_full;
  logic          q_pop;
  q_item_t       b_item;
  logic [AW-1:0] b_pidx;
  logic [AW-1:0] b_lim;

  assign accept  = start && !busy;
  assign busy    = q_full;
  assign q_wdata = {f_item, f_pidx, f_lim};
  assign {b_item, b_pidx, b_lim} = q_rdata;

  pal_front #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .item   (f_item),
    .pidx   (f_pidx),
    .lim    (f_lim)
  );

  pal_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  pal_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (b_item),
    .q_pidx  (b_pidx),
    .q_lim   (b_lim),
    .pop     (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== rtl/core/pal_checker.sv =====
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg and positional_array_list.
module pal_port_checks import pal_pkg::*; #(
  parameter int DEPTH = 128
) (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input cmd_t    cmd,
  input logic    busy,
  input logic    done,
  input result_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done high right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status <= ST_NOTFOUND)
    else $error("result status out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.found_position == '0 && result.read_value == '0)
    else $error("failed command carries position or data");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.found_position != '0 |-> result.status == ST_OK && result.read_value == '0)
    else $error("found position on a result that is not a successful search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> int'(result.element_count) <= DEPTH)
    else $error("element count above depth");

endmodule

bind positional_array_list pal_port_checks #(.DEPTH(DEPTH)) u_pal_checker (.*);

// ===== verif/pal_checker.sv =====
// Checker for the positional array list: watches the command and result channels,
// keeps its own copy of the list to predict each result word, and counts mismatches.
// Depends on pal_pkg.
module pal_checker import pal_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  input  logic    busy,
  input  logic    done,
  input  result_t result,
  output int      mismatches,
  output int      outstanding,
  output int      checked,
  output logic [4:0] status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] list_words [DEPTH];
  int                 list_len;
  result_t            due_results [$];

  function automatic result_t apply_list_cmd(cmd_t c);
    result_t r;
    int      p;
    int      i;
    r = '0;
    r.status = ST_OK;
    p = int'(c.position);
    case (c.op)
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = list_len; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = c.value;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_SEARCH: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          // Stop at the first match so that duplicates report the lowest position.
          for (i = 0; i < list_len && r.status == ST_NOTFOUND; i++) begin
            if (list_words[i] == c.value) begin
              r.status = ST_OK;
              r.found_position = 8'(i + 1);
            end
          end
        end
      end
      OP_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = list_words[p-1];
        end
      end
      default: begin
        r.status = ST_BADPOS;
      end
    endcase
    r.element_count = 8'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      list_len = 0;
      due_results.delete();
      mismatches <= 0;
      outstanding <= 0;
      checked <= 0;
      status_seen <= '0;
    end else begin
      // Results never come back on the edge that takes their command, so the
      // oldest expectation is retired before a new one is queued.
      if (done) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result word: status %0d found %0d read %0d count %0d",
                     $time, result.status, result.found_position, result.read_value,
                     result.element_count);
          mismatches <= mismatches + 1;
        end else begin
          want = due_results.pop_front();
          checked <= checked + 1;
          if (want.status <= ST_NOTFOUND) status_seen[want.status] <= 1'b1;
          if (result.status !== want.status ||
              result.found_position !== want.found_position ||
              result.read_value !== want.read_value ||
              result.element_count !== want.element_count) begin
            if (mismatches < 10)
              $display({"[%0t] result mismatch: status %0d/%0d found %0d/%0d ",
                        "read %0d/%0d count %0d/%0d (expected/actual)"},
                       $time, want.status, result.status,
                       want.found_position, result.found_position,
                       want.read_value, result.read_value,
                       want.element_count, result.element_count);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) due_results.push_back(apply_list_cmd(cmd));
      outstanding <= due_results.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Top of the positional array list testbench: clock, reset, command stimulus and verdict.
// Depends on pal_pkg, positional_array_list and pal_checker.
module tb import pal_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 400;

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  logic    done;
  result_t result;

  int         mismatches;
  int         outstanding;
  int         checked;
  logic [4:0] status_seen;

  int cycles = 0;
  int idle_pct;
  int issued;
  int fill;
  int peak_fill;
  logic signed [31:0] key_pool [$];

  positional_array_list #(.DEPTH(LIST_DEPTH)) DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  pal_checker #(.DEPTH(LIST_DEPTH)) checker_i (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .mismatches(mismatches), .outstanding(outstanding),
    .checked(checked), .status_seen(status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("positional_array_list verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 32'(int'($urandom_range(8)) - 4);
    if (r < 35) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Keeps a running tally of the list size so that positions can be aimed
  // at the valid range; idle cycles carry junk on cmd with start low.
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] pos,
                          input logic signed [31:0] val);
    cmd_t c;
    c.op = op;
    c.position = pos;
    c.value = val;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd <= cmd_t'({$urandom, $urandom});
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
    issued++;
    case (op)
      OP_CLEAR: fill = 0;
      OP_INSERT: begin
        if (fill < LIST_DEPTH && pos >= 1 && int'(pos) <= fill + 1) begin
          fill++;
          key_pool.push_back(val);
          if (key_pool.size() > 32) void'(key_pool.pop_front());
        end
      end
      OP_DELETE: if (fill > 0 && pos >= 1 && int'(pos) <= fill) fill--;
      default: ;
    endcase
    if (fill > peak_fill) peak_fill = fill;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int phase;
    int phase_end;
    int n;
    int k;
    int r;
    int base;
    int ins_pct;
    int del_pct;
    logic [7:0] pos;
    logic signed [31:0] val;
    logic [2:0] op;
    bit paused;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    idle_pct = 0;
    issued = 0;
    fill = 0;
    peak_fill = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-list refusals, edge positions, extreme values,
    // duplicate keys, unknown opcodes.
    send_cmd(OP_CLEAR, 8'd0, 32'sd0);
    send_cmd(OP_READ, 8'd1, 32'sd0);
    send_cmd(OP_DELETE, 8'd1, 32'sd0);
    send_cmd(OP_SEARCH, 8'd0, 32'sd0);
    send_cmd(OP_INSERT, 8'd0, 32'sd5);
    send_cmd(OP_INSERT, 8'd2, 32'sd5);
    send_cmd(OP_INSERT, 8'd1, 32'sh8000_0000);
    send_cmd(OP_INSERT, 8'd2, 32'sh7fff_ffff);
    send_cmd(OP_INSERT, 8'd1, 32'sd0);
    send_cmd(OP_INSERT, 8'd2, -32'sd1);
    send_cmd(OP_INSERT, 8'd5, -32'sd1);
    for (k = 1; k <= 6; k++) send_cmd(OP_READ, 8'(k), 32'sd0);
    send_cmd(OP_READ, 8'd255, 32'sd0);
    send_cmd(OP_SEARCH, 8'd0, -32'sd1);
    send_cmd(OP_SEARCH, 8'd0, 32'sd12345);
    send_cmd(OP_DELETE, 8'd5, 32'sd0);
    send_cmd(OP_DELETE, 8'd1, 32'sd0);
    send_cmd(OP_DELETE, 8'd0, 32'sd0);
    send_cmd(3'd5, 8'd1, 32'sd1);
    send_cmd(3'd7, 8'd255, -32'sd1);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 0;
        default: idle_pct = 7;
      endcase
      phase_end = issued + PHASE_WORDS;
      paused = 1'b0;
      while (issued < phase_end) begin
        if (!paused && issued > phase_end - PHASE_WORDS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 20) begin
          // Build a list from scratch by appends, now and then past capacity.
          send_cmd(OP_CLEAR, 8'($urandom), $urandom);
          n = ($urandom_range(99) < 25) ? LIST_DEPTH + int'($urandom_range(1, 3))
                                         : int'($urandom_range(1, 40));
          for (k = 0; k < n; k++) send_cmd(OP_INSERT, 8'(fill + 1), pick_value());
        end else if (r < 75) begin
          // Edits that lean toward growing, shrinking or neither.
          case ($urandom_range(2))
            0: begin ins_pct = 55; del_pct = 15; end
            1: begin ins_pct = 15; del_pct = 55; end
            default: begin ins_pct = 35; del_pct = 35; end
          endcase
          n = $urandom_range(10, 50);
          for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + del_pct) op = OP_DELETE;
            else if (r < ins_pct + del_pct + 15) op = OP_SEARCH;
            else if (r < 99) op = OP_READ;
            else op = OP_CLEAR;
            if ($urandom_range(99) < 15) pos = 8'($urandom_range(255));
            else if (op == OP_INSERT)
              pos = ($urandom_range(99) < 15) ? 8'(fill + 1) : 8'($urandom_range(1, fill + 1));
            else if (fill > 0) pos = 8'($urandom_range(1, fill));
            else pos = 8'($urandom_range(3));
            if (op == OP_SEARCH && key_pool.size() > 0 && $urandom_range(99) < 60)
              val = key_pool[$urandom_range(key_pool.size() - 1)];
            else
              val = pick_value();
            send_cmd(op, pos, val);
          end
        end else if (r < 85) begin
          // Walk a window of the list, then one past its end.
          base = (fill > 20) ? int'($urandom_range(fill - 20)) : 0;
          for (k = 1; k <= fill && k <= 20; k++) send_cmd(OP_READ, 8'(base + k), $urandom);
          send_cmd(OP_READ, 8'(fill + 1), $urandom);
        end else begin
          n = $urandom_range(3, 10);
          for (k = 0; k < n; k++)
            send_cmd(3'($urandom_range(7)), 8'($urandom_range(255)), $urandom);
        end
      end
      drain_results();
    end

    drain_results();
    repeat (150) @(negedge clk);
    $display("Covered %0d result words over four pacing phases; status codes seen: %b.",
             checked, status_seen);
    $display("The list reached %0d of %0d entries at its fullest.", peak_fill, LIST_DEPTH);
    if (mismatches == 0) begin
      $display("positional_array_list verification clean");
    end else begin
      $display("positional_array_list verification failed");
    end
    $finish;
  end

endmodule
